// ===== src/double_hash_key_value_table_assert.svh =====
// Concurrent assertion helpers, sampled on clk_i and disabled during reset.
`ifndef DOUBLE_HASH_KEY_VALUE_TABLE_ASSERT_SVH
`define DOUBLE_HASH_KEY_VALUE_TABLE_ASSERT_SVH

// Same-cycle implication.
`define DHKV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dhkv assertion failed");

// Next-cycle implication.
`define DHKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dhkv assertion failed");

`endif

// ===== src/dhkv_pkg.sv =====
`timescale 1ns / 1ps
package dhkv_pkg;

  localparam int CAPACITY_DEF   = 512;
  localparam int VALUE_BITS_DEF = 32;
  localparam int KEY_W          = 32;
  localparam int CFG_W          = 10;
  localparam logic [CFG_W-1:0] LEN_RESET = 10'd500;
  localparam int STEP_SHIFT     = 8;

  // Byte address of the length register on the APB port.
  localparam logic [2:0] ADDR_LEN = 3'd0;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_OVERWRITE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_INVALID   = 3'd5
  } status_e;

  // Request to the shared modulo unit.
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
  } mod_req_t;

endpackage

// ===== src/dhkv_mod.sv =====
`timescale 1ns / 1ps
// Restoring remainder unit: one dividend bit per cycle.
module dhkv_mod import dhkv_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int LW = $clog2(CAPACITY + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mod_req_t      req_i,
  input  logic [LW-1:0] divisor_i,
  output logic          done_o,
  output logic [AW-1:0] rem_o
);

  localparam int CW = $clog2(KEY_W);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [KEY_W-1:0] dvd_q;
  logic [LW-1:0]    rem_q;
  logic [LW:0]      trial;
  logic [LW-1:0]    rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[KEY_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      rem_d = LW'(trial - {1'b0, divisor_i});
    end else begin
      rem_d = trial[LW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(KEY_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[AW-1:0];

endmodule

// ===== src/double_hash_key_value_table.sv =====
`timescale 1ns / 1ps
// Open-addressed key/value table with double hashing.
// Input channel (in_valid_i/in_ready_o) carries one put or get beat: kind_i,
// key_i and value_i. Output channel (out_valid_o/out_ready_i) returns one
// result beat per input beat: status, slot, found value and the counters.
// The APB port holds the slot-count register at address 0; write it only while idle.
// After reset the key memory is swept to empty, one slot a cycle, over all
// CAPACITY slots; in_ready_o stays low during the sweep, APB writes are taken.
// Each beat runs through one shared remainder unit twice (home slot, then
// probe step), then each probe passes the registered memory read and the
// compare, between the accept and result states.
// A zero key or a put to a full table skips the hashing.
// The block takes one beat at a time. A result waits in the output register
// while the receiver stalls; the next beat can be accepted meanwhile, and its
// result is held back until the register is free.
module double_hash_key_value_table import dhkv_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [8:0]  slot_o,
  output logic [31:0] found_value_o,
  output logic [9:0]  used_count_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] miss_count_o,
  output logic [31:0] overwrite_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HOME, S_STEP, S_RD, S_CMP, S_DONE
  } state_e;

  state_e              state_q;
  logic [CFG_W-1:0]    cfg_len_q;
  logic [LW-1:0]       len_w, len_q;
  logic [AW-1:0]       clr_q;
  logic                kind_q;
  logic [KEY_W-1:0]    key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [AW-1:0]       pos_q, step_q;
  logic [LW-1:0]       p_q, occ_q;
  logic [31:0]         hits_q, misses_q, ovw_q;
  status_e             res_status_q;
  logic [AW-1:0]       res_slot_q;
  logic [VALUE_BITS-1:0] res_val_q;
  logic                out_valid_q;
  logic [2:0]          status_q;
  logic [8:0]          slot_q;
  logic [31:0]         fval_q, hitc_q, missc_q, ovwc_q;
  logic [9:0]          usedc_q;

  logic                accept, cfg_we;
  mod_req_t            mod_req;
  logic                mod_done;
  logic [AW-1:0]       mod_rem;
  logic [AW:0]         pos_sum;
  logic [AW-1:0]       pos_next;
  logic                more_probes;

  // Key and value memories, one write and one registered read per cycle.
  logic [KEY_W-1:0]      key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [KEY_W-1:0]      key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic                  key_we, val_we;
  logic [AW-1:0]         mem_wa;
  logic [KEY_W-1:0]      key_wd;

  // APB: one register, the table length, at index 0.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(cfg_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= LEN_RESET;
    end else if (cfg_we) begin
      cfg_len_q <= pwdata[CFG_W-1:0];
    end
  end

  // Clamp the length to 1..CAPACITY.
  always_comb begin
    if (cfg_len_q == '0) begin
      len_w = LW'(1);
    end else if (32'(cfg_len_q) > 32'(CAPACITY)) begin
      len_w = LW'(CAPACITY);
    end else begin
      len_w = LW'(cfg_len_q);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Home slot from the key, probe step from the key shifted down.
  always_comb begin
    mod_req.start    = 1'b0;
    mod_req.dividend = key_q >> STEP_SHIFT;
    if (state_q == S_IDLE) begin
      mod_req.dividend = key_i;
      mod_req.start    = accept && (key_i != '0) &&
                         !(!kind_i && (occ_q >= len_w));
    end else if (state_q == S_HOME) begin
      mod_req.start = mod_done;
    end
  end

  dhkv_mod #(.CAPACITY(CAPACITY)) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mod_req),
    .divisor_i(len_q),
    .done_o   (mod_done),
    .rem_o    (mod_rem)
  );

  // Next probe: pos is below len and step at most len, one subtract wraps it.
  always_comb begin
    pos_sum = {1'b0, pos_q} + {1'b0, step_q};
    if ((LW+1)'(pos_sum) >= (LW+1)'(len_q)) begin
      pos_next = AW'((LW+1)'(pos_sum) - (LW+1)'(len_q));
    end else begin
      pos_next = pos_sum[AW-1:0];
    end
    more_probes = (p_q != len_q - 1'b1);
  end

  // Memory writes: sweep during clear, insert or overwrite on compare.
  always_comb begin
    key_we = 1'b0;
    val_we = 1'b0;
    mem_wa = pos_q;
    key_wd = key_q;
    if (state_q == S_CLEAR) begin
      key_we = 1'b1;
      mem_wa = clr_q;
      key_wd = '0;
    end else if (state_q == S_CMP && !kind_q) begin
      if (key_rd_q == key_q) begin
        val_we = 1'b1;
      end else if (key_rd_q == '0) begin
        key_we = 1'b1;
        val_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[mem_wa] <= key_wd;
    end
    if (val_we) begin
      val_mem[mem_wa] <= val_q;
    end
    key_rd_q <= key_mem[pos_q];
    val_rd_q <= val_mem[pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      occ_q       <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      ovw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded this cycle.
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(CAPACITY - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_q     <= kind_i;
            key_q      <= key_i;
            val_q      <= VALUE_BITS'(value_i);
            len_q      <= len_w;
            res_slot_q <= '0;
            res_val_q  <= '0;
            // Reject a zero key, and a put to a table already full.
            if (key_i == '0) begin
              res_status_q <= ST_INVALID;
              state_q      <= S_DONE;
            end else if (!kind_i && (occ_q >= len_w)) begin
              res_status_q <= ST_FULL;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_HOME;
            end
          end
        end
        S_HOME: begin
          if (mod_done) begin
            pos_q   <= mod_rem;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (mod_done) begin
            step_q  <= (mod_rem == '0) ? AW'(1) : mod_rem;
            p_q     <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          state_q <= S_DONE;
          if (key_rd_q == key_q) begin
            res_slot_q <= pos_q;
            if (kind_q) begin
              hits_q       <= hits_q + 1'b1;
              res_status_q <= ST_FOUND;
              res_val_q    <= val_rd_q;
            end else begin
              ovw_q        <= ovw_q + 1'b1;
              res_status_q <= ST_OVERWRITE;
            end
          end else if (key_rd_q == '0) begin
            if (kind_q) begin
              res_status_q <= ST_NOT_FOUND;
            end else begin
              occ_q        <= occ_q + 1'b1;
              res_slot_q   <= pos_q;
              res_status_q <= ST_INSERTED;
            end
          end else if (more_probes) begin
            // Collision: advance to the next probe.
            if (kind_q) begin
              misses_q <= misses_q + 1'b1;
            end
            pos_q   <= pos_next;
            p_q     <= p_q + 1'b1;
            state_q <= S_RD;
          end else begin
            res_status_q <= kind_q ? ST_NOT_FOUND : ST_FULL;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            slot_q      <= 9'(res_slot_q);
            fval_q      <= 32'(res_val_q);
            usedc_q     <= 10'(occ_q);
            hitc_q      <= hits_q;
            missc_q     <= misses_q;
            ovwc_q      <= ovw_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign slot_o            = slot_q;
  assign found_value_o     = fval_q;
  assign used_count_o      = usedc_q;
  assign hit_count_o       = hitc_q;
  assign miss_count_o      = missc_q;
  assign overwrite_count_o = ovwc_q;

`include "double_hash_key_value_table_assert.svh"

  `DHKV_ASSERT_NOW(a_clear_blocks_input, state_q == S_CLEAR, !in_ready_o)
  `DHKV_ASSERT_NEXT(a_accept_goes_busy, accept, !in_ready_o)
  `DHKV_ASSERT_NOW(a_probe_in_range, state_q == S_RD || state_q == S_CMP, LW'(pos_q) < len_q)

endmodule

// ===== bench/dhkv_checker.sv =====
`timescale 1ns / 1ps
module dhkv_checker import dhkv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        kind_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [8:0]  slot_i,
  input  logic [31:0] found_value_i,
  input  logic [9:0]  used_count_i,
  input  logic [31:0] hit_count_i,
  input  logic [31:0] miss_count_i,
  input  logic [31:0] overwrite_count_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int SLOTS = CAPACITY_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  slot;
    logic [31:0] found_value;
    logic [9:0]  used;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] overwrites;
  } lookup_result_t;

  logic [31:0]    key_mem [SLOTS];
  logic [31:0]    val_mem [SLOTS];
  logic [9:0]     occupied;
  logic [31:0]    hits, misses, overwrites;
  logic [9:0]     table_len;
  lookup_result_t expected_q[$];
  int             fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("dhkv check: %s got 0x%08h expected 0x%08h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  function automatic lookup_result_t run_table_op(input logic kind, input logic [31:0] key,
                                                   input logic [31:0] val);
    lookup_result_t r;
    bit [31:0] len, pos, step;
    int p;
    len = (table_len == 0) ? 1 : ((table_len > SLOTS) ? SLOTS : table_len);
    pos  = key % len;
    step = (key >> STEP_SHIFT) % len;
    if (step == 0) step = 1;
    r = '0;
    if (key == 0) begin
      r.status = ST_INVALID;
    end else if (kind == 1'b0) begin
      r.status = ST_FULL;
      if (occupied < len) begin
        for (p = 0; p < len; p++) begin
          if (key_mem[pos] == key) begin
            overwrites++;
            val_mem[pos] = val;
            r.status = ST_OVERWRITE;
            r.slot = pos[8:0];
            break;
          end
          if (key_mem[pos] == 0) begin
            key_mem[pos] = key;
            val_mem[pos] = val;
            occupied++;
            r.status = ST_INSERTED;
            r.slot = pos[8:0];
            break;
          end
          pos = (pos + step) % len;
        end
      end
    end else begin
      r.status = ST_NOT_FOUND;
      for (p = 0; p < len; p++) begin
        if (key_mem[pos] == key) begin
          hits++;
          r.status = ST_FOUND;
          r.slot = pos[8:0];
          r.found_value = val_mem[pos];
          break;
        end
        if (key_mem[pos] == 0) break;
        if (p + 1 < len) begin
          misses++;
          pos = (pos + step) % len;
        end
      end
    end
    r.used = occupied;
    r.hits = hits;
    r.misses = misses;
    r.overwrites = overwrites;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        key_mem[i] = '0;
        val_mem[i] = '0;
      end
      occupied = '0;
      hits = '0;
      misses = '0;
      overwrites = '0;
      table_len = LEN_RESET;
      expected_q.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_LEN) begin
        table_len = pwdata[9:0];
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(run_table_op(kind_i, key_i, value_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result beat", {29'd0, status_i}, '0);
        end else begin
          want = expected_q.pop_front();
          if (status_i != want.status) report("status", status_i, want.status);
          if (slot_i != want.slot) report("slot", slot_i, want.slot);
          if (found_value_i != want.found_value)
            report("found_value", found_value_i, want.found_value);
          if (used_count_i != want.used) report("used_count", used_count_i, want.used);
          if (hit_count_i != want.hits) report("hit_count", hit_count_i, want.hits);
          if (miss_count_i != want.misses) report("miss_count", miss_count_i, want.misses);
          if (overwrite_count_i != want.overwrites)
            report("overwrite_count", overwrite_count_i, want.overwrites);
        end
      end
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import dhkv_pkg::*;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic        kind_i;
  logic [31:0] key_i, value_i;
  logic        out_valid_o, out_ready_i;
  logic [2:0]  status_o;
  logic [8:0]  slot_o;
  logic [31:0] found_value_o;
  logic [9:0]  used_count_o;
  logic [31:0] hit_count_o, miss_count_o, overwrite_count_o;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          fail_count, pending;
  int          idle_cycles = 0;
  logic [31:0] key_pool [64];
  int          burst_left;

  double_hash_key_value_table uut (.*);

  dhkv_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .key_i, .value_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .slot_i(slot_o), .found_value_i(found_value_o),
    .used_count_i(used_count_o), .hit_count_i(hit_count_o),
    .miss_count_i(miss_count_o), .overwrite_count_i(overwrite_count_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("double_hash_key_value_table: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: each cycle picks free flow, a random ready or a stall.
  always @(posedge clk_i) begin
    int mode;
    mode = $urandom_range(0, 99);
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (mode < 50) out_ready_i <= 1'b1;
    else if (mode < 85) out_ready_i <= $urandom_range(0, 1);
    else out_ready_i <= 1'b0;
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drive one beat and hold it until accepted; gaps fall between bursts.
  task automatic send_beat(input logic kind, input logic [31:0] key, input logic [31:0] val);
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    value_i    <= val;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    key_pool[$urandom_range(0, 63)] = key;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  // Drain: hold the sender until every expected result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 32'd0;
    if (sel < 50) return key_pool[$urandom_range(0, 63)];
    if (sel < 62) return $urandom_range(1, 255);
    if (sel < 65) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  initial begin
    logic [9:0] lengths [10];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = 1'b0;
    key_i       = '0;
    value_i     = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    burst_left  = 0;
    for (int i = 0; i < 64; i++) key_pool[i] = $urandom;
    // Occupancy never drops, so grow the table length from phase to phase, then end at 0 (clamped to 1).
    lengths = '{10'd5, 10'd8, 10'd20, 10'd60, 10'd150, 10'd300,
                10'd500, 10'd512, 10'd1023, 10'd0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats at the reset length: invalid key, extremes, collisions.
    send_beat(KIND_PUT, 32'd0, 32'hFFFF_FFFF);
    send_beat(KIND_GET, 32'd0, 32'hFFFF_FFFF);
    send_beat(KIND_GET, 32'd12345, 32'd0);
    send_beat(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(KIND_GET, 32'hFFFF_FFFF, 32'd0);
    send_beat(KIND_PUT, 32'hFFFF_FFFF, 32'd0);
    send_beat(KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(KIND_PUT, 32'd500, 32'h1234_5678);
    send_beat(KIND_PUT, 32'd1000, 32'h8765_4321);
    send_beat(KIND_PUT, 32'd1500, 32'hA5A5_5A5A);
    send_beat(KIND_GET, 32'd1000, 32'd0);
    send_beat(KIND_GET, 32'd1500, 32'd0);
    send_beat(KIND_GET, 32'd2000, 32'd0);
    send_beat(KIND_PUT, 32'd1, 32'h0000_0001);
    send_beat(KIND_GET, 32'd1, 32'd0);
    send_beat(KIND_GET, 32'd501, 32'd0);
    drain();

    foreach (lengths[ph]) begin
      apb_write(ADDR_LEN, {22'd0, lengths[ph]});
      for (int n = 0; n < 115; n++) begin
        logic k;
        k = ($urandom_range(0, 99) < 55) ? KIND_PUT : KIND_GET;
        send_beat(k, pick_key(), $urandom);
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("double_hash_key_value_table: match");
    end else begin
      $display("double_hash_key_value_table: mismatch");
    end
    $finish;
  end

endmodule
